// ----- rtl/run_queue_with_keyed_removal_defines.svh -----
// ----------------------------------------------------------------------------
// Run queue assertion macros
// Concurrent check helpers, compiled out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef RUN_QUEUE_WITH_KEYED_REMOVAL_DEFINES_SVH
`define RUN_QUEUE_WITH_KEYED_REMOVAL_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked on clk, off during reset
`define RQKR_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("run queue check failed");
// next-cycle implication
`define RQKR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("run queue check failed");
`else
`define RQKR_ASSERT_IMPL(lbl, ante, cons)
`define RQKR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/rqkr_pkg.sv -----
// ----------------------------------------------------------------------------
// Run queue package
// Action and status codes, request/response words and cell control.
// ----------------------------------------------------------------------------
`default_nettype none

package rqkr_pkg;

	localparam logic [2:0] ACT_ENQ    = 3'd0;
	localparam logic [2:0] ACT_DEQ    = 3'd1;
	localparam logic [2:0] ACT_ROT    = 3'd2;
	localparam logic [2:0] ACT_REMOVE = 3'd3;
	localparam logic [2:0] ACT_QUERY  = 3'd4;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_EMPTY     = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_FULL      = 2'd3;

	typedef struct packed {
		logic [2:0]  action;
		logic [15:0] thread_id;
	} req_t;

	typedef struct packed {
		logic [15:0] thread_id_out;
		logic        found;
		logic [1:0]  status;
		logic        empty_res;
		logic [4:0]  entry_count;
	} rsp_t;

	// broadcast to every cell; enq, deq and rot already gated by empty/full
	typedef struct packed {
		logic enq;
		logic deq;
		logic rot;
		logic rem;
	} cell_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/run_queue_with_keyed_removal.sv -----
// ----------------------------------------------------------------------------
// Run queue with keyed removal
// FIFO of thread identifiers built as a chain of slot cells.
// ----------------------------------------------------------------------------
// One request word is taken in every cycle (busy stays low) and its response
// appears on rsp with done high in the following cycle; the receiver cannot
// stall it. All DEPTH cells compare against the request identifier in
// parallel and a hit flag ripples from head to tail, so the first match and
// the gap it leaves are handled in the same cycle; that ripple through the
// cell chain sets the clock limit.
`default_nettype none
`include "run_queue_with_keyed_removal_defines.svh"

module run_queue_with_keyed_removal
	import rqkr_pkg::*;
#(
	parameter int DEPTH    = 16,
	parameter int ID_WIDTH = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	input  wire req_t req,
	output logic      done,
	output rsp_t      rsp
);

	localparam int CNT_W = $clog2(DEPTH + 1);

	logic                accept;
	logic [ID_WIDTH-1:0] id;
	logic                empty;
	logic                full;
	logic                any_hit;
	cell_ctl_t           ctl;

	logic [DEPTH-1:0]    valid_w;
	logic [ID_WIDTH-1:0] entry_w [DEPTH];
	logic [DEPTH:0]      hit_w;

	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    count_d;
	logic                done_q;
	rsp_t                rsp_q;
	rsp_t                rsp_d;

	// a word is taken in every cycle
	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign id     = ID_WIDTH'(req.thread_id);
	assign empty  = !valid_w[0];
	assign full   = valid_w[DEPTH-1];

	assign ctl.enq = accept && (req.action == ACT_ENQ) && !full;
	assign ctl.deq = accept && (req.action == ACT_DEQ) && !empty;
	assign ctl.rot = accept && (req.action == ACT_ROT) && !empty;
	assign ctl.rem = accept && (req.action == ACT_REMOVE);

	assign hit_w[0] = 1'b0;
	assign any_hit  = hit_w[DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                prev_v;
		logic                next_v;
		logic [ID_WIDTH-1:0] next_e;

		if (i == 0) begin : g_head
			assign prev_v = 1'b1;
		end else begin : g_mid
			assign prev_v = valid_w[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign next_v = 1'b0;
			assign next_e = '0;
		end else begin : g_body
			assign next_v = valid_w[i+1];
			assign next_e = entry_w[i+1];
		end

		rqkr_cell #(
			.ID_WIDTH(ID_WIDTH)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.id        (id),
			.head_id   (entry_w[0]),
			.prev_valid(prev_v),
			.next_valid(next_v),
			.next_entry(next_e),
			.hit_in    (hit_w[i]),
			.valid     (valid_w[i]),
			.entry     (entry_w[i]),
			.hit_out   (hit_w[i+1])
		);
	end

	always_comb begin
		count_d = count_q;
		rsp_d   = '0;
		unique case (req.action)
			ACT_ENQ: begin
				if (full) begin
					rsp_d.status = ST_FULL;
				end else begin
					count_d = count_q + CNT_W'(1);
				end
			end
			ACT_DEQ, ACT_ROT: begin
				if (empty) begin
					rsp_d.status = ST_EMPTY;
				end else begin
					rsp_d.thread_id_out = 16'(entry_w[0]);
					rsp_d.found         = 1'b1;
					if (req.action == ACT_DEQ) begin
						count_d = count_q - CNT_W'(1);
					end
				end
			end
			ACT_REMOVE, ACT_QUERY: begin
				if (empty) begin
					rsp_d.status = ST_EMPTY;
				end else if (!any_hit) begin
					rsp_d.status = ST_NOT_FOUND;
				end else begin
					rsp_d.found = 1'b1;
					if (req.action == ACT_REMOVE) begin
						// the removed entry equals the key
						rsp_d.thread_id_out = 16'(id);
						count_d             = count_q - CNT_W'(1);
					end
				end
			end
			default: begin
			end
		endcase
		rsp_d.entry_count = 5'(count_d);
		rsp_d.empty_res   = (count_d == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= accept;
			if (accept) begin
				count_q <= count_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_d;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	logic [DEPTH:0] thermo_w;
	assign thermo_w = {1'b0, valid_w} + (DEPTH + 1)'(1);

	`RQKR_ASSERT_IMPL(a_valid_packed, 1'b1, $onehot(thermo_w))
	`RQKR_ASSERT_IMPL(a_count_match, 1'b1, $countones(valid_w) == count_q)
	`RQKR_ASSERT_NEXT(a_done_follows, accept, done)
	`RQKR_ASSERT_NEXT(a_full_drop, accept && (req.action == ACT_ENQ) && full, rsp.status == ST_FULL)

endmodule

`default_nettype wire

// ----- rtl/rqkr_cell.sv -----
// ----------------------------------------------------------------------------
// Run queue cell
// One queue slot: holds an identifier and a valid bit, shifts toward the head.
// ----------------------------------------------------------------------------
`default_nettype none

module rqkr_cell
	import rqkr_pkg::*;
#(
	parameter int ID_WIDTH = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire cell_ctl_t           ctl,
	input  wire logic [ID_WIDTH-1:0] id,
	input  wire logic [ID_WIDTH-1:0] head_id,
	input  wire logic                prev_valid,
	input  wire logic                next_valid,
	input  wire logic [ID_WIDTH-1:0] next_entry,
	input  wire logic                hit_in,
	output logic                     valid,
	output logic [ID_WIDTH-1:0]      entry,
	output logic                     hit_out
);

	logic                valid_q;
	logic [ID_WIDTH-1:0] entry_q;
	logic                valid_d;
	logic [ID_WIDTH-1:0] entry_d;
	logic                match;

	assign match   = valid_q && (entry_q == id);
	assign hit_out = hit_in || match;

	always_comb begin
		valid_d = valid_q;
		entry_d = entry_q;
		priority if (ctl.enq) begin
			// first free slot takes the new word
			if (!valid_q && prev_valid) begin
				valid_d = 1'b1;
				entry_d = id;
			end
		end else if (ctl.deq) begin
			valid_d = next_valid;
			entry_d = next_entry;
		end else if (ctl.rot) begin
			// tail slot takes the old head, the rest advance
			entry_d = (valid_q && !next_valid) ? head_id : next_entry;
		end else if (ctl.rem && hit_out) begin
			// at or behind the first match: close the gap
			valid_d = next_valid;
			entry_d = next_entry;
		end else begin
			// hold
			valid_d = valid_q;
			entry_d = entry_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

	assign valid = valid_q;
	assign entry = entry_q;

endmodule

`default_nettype wire

// ----- test/run_queue_with_keyed_removal_test.sv -----
// ----------------------------------------------------------------------------
// Run queue with keyed removal: self-checking testbench
// Drives request words through the start/busy handshake and keeps its own
// model of the queue, which gives the expected response word for each request.
// A monitor compares every response on done with the oldest expected word.
// Directed cases cover the empty queue, the full queue, the removal of the tail
// and the unused action codes. A long random mix follows: first with random
// gaps, then back to back.
// ----------------------------------------------------------------------------

module run_queue_with_keyed_removal_test;
	import rqkr_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUEUE_DEPTH = 16;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 4;

	// action codes that the block takes but does nothing with
	localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
	localparam logic [2:0] ACT_SPARE_LAST  = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	req_t req = '0;
	logic done;
	rsp_t rsp;

	logic [15:0] run_list[$];
	rsp_t        pending_rsp[$];
	int          fail_count = 0;
	int          cycle_count = 0;

	run_queue_with_keyed_removal #(
		.DEPTH(QUEUE_DEPTH),
		.ID_WIDTH(16)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words outstanding",
				cycle_count, pending_rsp.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	// Apply one request to the run list and return the response it must give.
	function automatic rsp_t apply_action(req_t w);
		rsp_t r;
		int pos;
		r = '0;
		pos = -1;
		case (w.action)
			ACT_ENQ: begin
				if (run_list.size() >= QUEUE_DEPTH)
					r.status = ST_FULL;
				else
					run_list.push_back(w.thread_id);
			end
			ACT_DEQ, ACT_ROT: begin
				if (run_list.size() == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.thread_id_out = run_list.pop_front();
					r.found = 1'b1;
					if (w.action == ACT_ROT)
						run_list.push_back(r.thread_id_out);
				end
			end
			ACT_REMOVE, ACT_QUERY: begin
				if (run_list.size() == 0) begin
					r.status = ST_EMPTY;
				end else begin
					foreach (run_list[i])
						if (pos < 0 && run_list[i] == w.thread_id)
							pos = i;
					if (pos < 0) begin
						r.status = ST_NOT_FOUND;
					end else begin
						r.found = 1'b1;
						if (w.action == ACT_REMOVE) begin
							r.thread_id_out = run_list[pos];
							run_list.delete(pos);
						end
					end
				end
			end
			default: ;
		endcase
		r.empty_res = (run_list.size() == 0);
		r.entry_count = 5'(run_list.size());
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
		fail_count++;
		$display("%0t: %s mismatch: got %0h, expected %0h", $realtime, what, got, want);
	endtask

	task automatic check_field(string what, logic [15:0] got, logic [15:0] want);
		if (got !== want)
			report_mismatch(what, got, want);
	endtask

	// Sample responses away from the clock edge.
	always @(negedge clk) begin
		rsp_t want;
		if (arst_n && done === 1'b1) begin
			if (pending_rsp.size() == 0) begin
				report_mismatch("unexpected response word", rsp.thread_id_out, 16'h0000);
			end else begin
				want = pending_rsp.pop_front();
				check_field("thread_id_out", rsp.thread_id_out, want.thread_id_out);
				check_field("found", 16'(rsp.found), 16'(want.found));
				check_field("status", 16'(rsp.status), 16'(want.status));
				check_field("empty_res", 16'(rsp.empty_res), 16'(want.empty_res));
				check_field("entry_count", 16'(rsp.entry_count), 16'(want.entry_count));
			end
		end
	end

	// Called at a rising edge; returns at the edge that takes the word.
	// Start stays high so that a following word goes out back to back.
	task automatic send_word(logic [2:0] act, logic [15:0] id);
		req_t w;
		w.action = act;
		w.thread_id = id;
		req <= w;
		start <= 1'b1;
		do @(negedge clk); while (busy !== 1'b0);
		@(posedge clk);
		pending_rsp.push_back(apply_action(w));
	endtask

	task automatic idle_for(int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic test_empty_and_edges();
		// every lookup action on an empty queue
		send_word(ACT_DEQ, 16'h1234);
		send_word(ACT_ROT, 16'hffff);
		send_word(ACT_REMOVE, 16'h0000);
		send_word(ACT_QUERY, 16'hffff);
		idle_for(3);
		send_word(ACT_ENQ, 16'h0000);
		send_word(ACT_ENQ, 16'hffff);
		send_word(ACT_QUERY, 16'hffff);
		send_word(ACT_QUERY, 16'h1234);
		send_word(ACT_REMOVE, 16'h1234);
		send_word(ACT_ROT, 16'h0000);
		// zero now sits at the tail: take out the last entry
		send_word(ACT_REMOVE, 16'h0000);
		send_word(ACT_ROT, 16'h5555);
		send_word(ACT_ENQ, 16'haaaa);
		send_word(ACT_DEQ, 16'h0000);
		send_word(ACT_REMOVE, 16'haaaa);
		idle_for(1);
		for (int a = ACT_SPARE_FIRST; a <= ACT_SPARE_LAST; a++)
			send_word(a[2:0], 16'hffff);
		send_word(ACT_ENQ, 16'h8001);
		send_word(ACT_DEQ, 16'h0000);
	endtask

	task automatic test_full_queue();
		// fill with duplicates, then push past the top
		for (int i = 0; i < QUEUE_DEPTH; i++)
			send_word(ACT_ENQ, 16'h0100 + 16'(i % 5));
		send_word(ACT_ENQ, 16'haaaa);
		send_word(ACT_ENQ, 16'h5555);
		send_word(ACT_QUERY, 16'h5555);
		send_word(ACT_REMOVE, 16'h0102);
		send_word(ACT_ENQ, 16'hc3c3);
		send_word(ACT_ENQ, 16'h3c3c);
		send_word(ACT_REMOVE, 16'hc3c3);
		send_word(ACT_ROT, 16'h0000);
		send_word(ACT_QUERY, 16'h0100);
		idle_for(2);
		for (int i = 0; i < QUEUE_DEPTH + 1; i++)
			send_word(ACT_DEQ, 16'(i));
	endtask

	task automatic test_random_mix(int count, bit with_gaps);
		logic [15:0] id_pool[6];
		logic [2:0]  act;
		logic [15:0] id;
		bit          filling;
		int          phase_left;
		int          pick;
		foreach (id_pool[i])
			id_pool[i] = 16'($urandom_range(16'hffff, 0));
		filling = 1'b1;
		phase_left = 0;
		for (int n = 0; n < count; n++) begin
			// swing between filling and draining so both ends are reached
			if (phase_left == 0) begin
				filling = ~filling;
				phase_left = $urandom_range(60, 15);
			end
			phase_left--;
			pick = $urandom_range(99, 0);
			if (pick < (filling ? 45 : 15))
				act = ACT_ENQ;
			else if (pick < (filling ? 55 : 45))
				act = ACT_DEQ;
			else if (pick < 62)
				act = ACT_ROT;
			else if (pick < 78)
				act = ACT_REMOVE;
			else if (pick < 95)
				act = ACT_QUERY;
			else
				act = 3'($urandom_range(ACT_SPARE_LAST, ACT_SPARE_FIRST));
			if ($urandom_range(9, 0) < 7)
				id = id_pool[$urandom_range(5, 0)];
			else
				id = 16'($urandom_range(16'hffff, 0));
			send_word(act, id);
			if (with_gaps && $urandom_range(4, 0) == 0)
				idle_for($urandom_range(14, 1));
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_and_edges();
		test_full_queue();
		test_random_mix(1000, 1'b1);
		test_random_mix(150, 1'b0);
		start <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/rqkr_pkg.sv
rtl/rqkr_cell.sv
rtl/run_queue_with_keyed_removal.sv
test/run_queue_with_keyed_removal_test.sv
